### rtl/ssm_pkg.sv
// shared types and constants for the signal subscription matcher
// used by ssm_cell, signal_subscription_matcher_top and ssm_checker
package ssm_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned SIG_W       = 32;
    localparam int unsigned TTL_W       = 16;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned SOLO_SLOTS  = 2 ** SLOT_W;

    typedef enum logic [1:0] {
        OP_DISPATCH  = 2'd0,
        OP_SUBSCRIBE = 2'd1,
        OP_SOLO      = 2'd2,
        OP_TICK      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_DELIVERED  = 3'd0,
        KIND_TIMEOUT    = 3'd1,
        KIND_SUBSCRIBED = 3'd2,
        KIND_FULL       = 3'd3,
        KIND_NONE       = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // command broadcast from the sequencer to every cell
    typedef struct packed {
        logic             shift;
        logic             step;
        logic             sub_wr;
        logic             solo_set;
        logic             solo_clr;
        logic             solo_on;
        t_op              op;
        logic [SIG_W-1:0] sig;
        logic [SIG_W-1:0] mask;
        logic [TTL_W-1:0] ttl;
    } t_cell_cmd;

endpackage

### rtl/signal_subscription_matcher_top.sv
// signal subscription matcher: sequencer, result registers and a row of ssm_cell
// depends on ssm_pkg and ssm_cell
//
// Each accepted item produces one or more result transfers, the final one with tlast.
// A dispatch or a tick walks a token down the row of cells from the highest entry to
// entry 0, one cell per cycle while the result output can take each new result; the
// walk holds only when a second result is waiting and the output is stalled. A stalled
// output also delays the final result of every item, subscribes and solo ops included.
// Results of one item come newest entry first, at most 16 per item; further deliveries
// and expiries still update the table. Items are taken one at a time.
module signal_subscription_matcher_top #(
    parameter int unsigned ENTRIES = ssm_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // signal[31:0], mask[63:32], ttl[79:64], solo_enable[80], solo_slot[84:81]
    input  logic [87:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot[3:0], matched_signal[35:4]
    output logic [39:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import ssm_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned FW = $clog2(ENTRIES + 1);

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [SIG_W-1:0]    r_sig, n_sig;
    logic [SIG_W-1:0]    r_mask, n_mask;
    logic [TTL_W-1:0]    r_ttl, n_ttl;
    logic                r_en, n_en;
    logic [SLOT_W-1:0]   r_sslot, n_sslot;
    logic [FW-1:0]       r_fill, n_fill;
    logic                r_solo_on, n_solo_on;
    logic [SLOT_W-1:0]   r_solo_idx, n_solo_idx;
    logic [IW-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_held_v, n_held_v;
    t_kind               r_held_kind, n_held_kind;
    logic [SLOT_W-1:0]   r_held_slot, n_held_slot;
    logic [SIG_W-1:0]    r_held_sig, n_held_sig;
    logic                r_out_v, n_out_v;
    t_kind               r_out_kind, n_out_kind;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [SIG_W-1:0]    r_out_sig, n_out_sig;
    logic                r_out_last, n_out_last;

    t_cell_cmd           w_cmd;
    logic [ENTRIES-1:0]  w_tok;
    logic [ENTRIES-1:0]  w_tok_in;
    logic [ENTRIES-1:0]  w_hits;
    logic [ENTRIES-1:0]  w_fill_sel;
    logic [ENTRIES-1:0]  w_solo_sel;
    logic [ENTRIES-1:0]  w_new_sel;
    logic                w_start;
    logic                w_hit;
    logic                w_report;
    logic                w_out_free;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            if (g == ENTRIES - 1) begin : g_head
                assign w_tok_in[g] = w_start;
            end else begin : g_link
                assign w_tok_in[g] = w_tok[g+1];
            end
            assign w_fill_sel[g] = (r_fill == FW'(g));
            assign w_solo_sel[g] = (g < SOLO_SLOTS) ? (r_solo_idx == SLOT_W'(g)) : 1'b0;
            assign w_new_sel[g]  = (g < SOLO_SLOTS) ? (r_sslot == SLOT_W'(g)) : 1'b0;

            ssm_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_cmd          (w_cmd),
                .i_token        (w_tok_in[g]),
                .i_fill_sel     (w_fill_sel[g]),
                .i_solo_sel     (w_solo_sel[g]),
                .i_new_solo_sel (w_new_sel[g]),
                .o_token        (w_tok[g]),
                .o_hit          (w_hits[g])
            );
        end
    endgenerate

    assign w_hit      = |w_hits;
    assign w_report   = w_hit && (r_cnt < CNT_W'(MAX_RESULTS));
    assign w_out_free = !r_out_v || m_axis_tready;
    assign w_start    = w_cmd.shift && (r_state == ST_EXEC);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {4'b0000, r_out_sig, r_out_slot};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sig       = r_sig;
        n_mask      = r_mask;
        n_ttl       = r_ttl;
        n_en        = r_en;
        n_sslot     = r_sslot;
        n_fill      = r_fill;
        n_solo_on   = r_solo_on;
        n_solo_idx  = r_solo_idx;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_held_v    = r_held_v;
        n_held_kind = r_held_kind;
        n_held_slot = r_held_slot;
        n_held_sig  = r_held_sig;
        n_out_v     = r_out_v;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_sig   = r_out_sig;
        n_out_last  = r_out_last;

        w_cmd          = '0;
        w_cmd.solo_on  = r_solo_on;
        w_cmd.op       = r_op;
        w_cmd.sig      = r_sig;
        w_cmd.mask     = r_mask;
        w_cmd.ttl      = r_ttl;

        if (r_out_v && m_axis_tready) begin
            n_out_v = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = t_op'(s_axis_tuser);
                    n_sig   = s_axis_tdata[31:0];
                    n_mask  = s_axis_tdata[63:32];
                    n_ttl   = s_axis_tdata[79:64];
                    n_en    = s_axis_tdata[80];
                    n_sslot = s_axis_tdata[84:81];
                    n_cnt   = '0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_FINISH;
                case (r_op)
                    OP_DISPATCH, OP_TICK: begin
                        // hand the token to the highest entry
                        w_cmd.shift = 1'b1;
                        n_idx       = IW'(ENTRIES - 1);
                        n_state     = ST_SCAN;
                    end
                    OP_SUBSCRIBE: begin
                        n_held_v   = 1'b1;
                        n_held_sig = '0;
                        if (r_fill < FW'(ENTRIES)) begin
                            w_cmd.sub_wr = 1'b1;
                            n_fill       = r_fill + FW'(1);
                            n_held_kind  = KIND_SUBSCRIBED;
                            n_held_slot  = SLOT_W'(r_fill);
                        end else begin
                            n_held_kind = KIND_FULL;
                            n_held_slot = '0;
                        end
                    end
                    OP_SOLO: begin
                        if (r_en) begin
                            w_cmd.solo_set = 1'b1;
                            n_solo_on      = 1'b1;
                            n_solo_idx     = r_sslot;
                        end else begin
                            w_cmd.solo_clr = 1'b1;
                            n_solo_on      = 1'b0;
                            n_solo_idx     = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SCAN: begin
                // hold the token while a second result has nowhere to go
                if (!(w_report && r_held_v && !w_out_free)) begin
                    w_cmd.shift = 1'b1;
                    w_cmd.step  = 1'b1;
                    n_idx       = r_idx - IW'(1);
                    if (w_report) begin
                        if (r_held_v) begin
                            n_out_v    = 1'b1;
                            n_out_kind = r_held_kind;
                            n_out_slot = r_held_slot;
                            n_out_sig  = r_held_sig;
                            n_out_last = 1'b0;
                        end
                        n_held_v    = 1'b1;
                        n_held_kind = (r_op == OP_DISPATCH) ? KIND_DELIVERED : KIND_TIMEOUT;
                        n_held_slot = SLOT_W'(r_idx);
                        n_held_sig  = (r_op == OP_DISPATCH) ? r_sig : '0;
                        n_cnt       = r_cnt + CNT_W'(1);
                    end
                    if (w_tok[0]) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out_last = 1'b1;
                    if (r_held_v) begin
                        n_out_kind = r_held_kind;
                        n_out_slot = r_held_slot;
                        n_out_sig  = r_held_sig;
                    end else begin
                        n_out_kind = KIND_NONE;
                        n_out_slot = '0;
                        n_out_sig  = '0;
                    end
                    n_held_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_solo_on  <= 1'b0;
            r_solo_idx <= '0;
            r_held_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_solo_on  <= n_solo_on;
            r_solo_idx <= n_solo_idx;
            r_held_v   <= n_held_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_sig       <= n_sig;
        r_mask      <= n_mask;
        r_ttl       <= n_ttl;
        r_en        <= n_en;
        r_sslot     <= n_sslot;
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_held_kind <= n_held_kind;
        r_held_slot <= n_held_slot;
        r_held_sig  <= n_held_sig;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_sig   <= n_out_sig;
        r_out_last  <= n_out_last;
    end

endmodule

### rtl/ssm_cell.sv
// one subscription entry: value, mask, lifetime and countdown
// passes the scan token to its lower neighbor; depends on ssm_pkg
module ssm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssm_pkg::t_cell_cmd i_cmd,
    input  logic              i_token,
    input  logic              i_fill_sel,
    input  logic              i_solo_sel,
    input  logic              i_new_solo_sel,
    output logic              o_token,
    output logic              o_hit
);
    import ssm_pkg::*;

    logic             r_token;
    logic             r_used;
    logic             r_armed;
    logic [SIG_W-1:0] r_value;
    logic [SIG_W-1:0] r_mask;
    logic [TTL_W-1:0] r_life;
    logic [TTL_W-1:0] r_count;

    logic w_deliver;
    logic w_expire;
    logic w_act;
    logic w_rearm;
    logic w_new;

    assign w_deliver = r_used && (!i_cmd.solo_on || i_solo_sel)
                       && ((i_cmd.sig & r_mask) == r_value);
    assign w_expire  = r_armed && (r_count <= TTL_W'(1));
    assign w_act     = r_token && i_cmd.step;
    assign w_new     = i_cmd.sub_wr && i_fill_sel;
    // leaving solo re-arms every filled entry with a nonzero lifetime except the solo one
    assign w_rearm   = i_cmd.solo_clr && r_used && !(i_cmd.solo_on && i_solo_sel)
                       && (r_life != '0);

    assign o_token = r_token;
    assign o_hit   = r_token && (((i_cmd.op == OP_DISPATCH) && w_deliver)
                              || ((i_cmd.op == OP_TICK) && w_expire));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
            r_used  <= 1'b0;
            r_armed <= 1'b0;
        end else begin
            if (i_cmd.shift) begin
                r_token <= i_token;
            end
            if (w_new) begin
                r_used  <= 1'b1;
                r_armed <= (i_cmd.ttl != '0);
            end
            if (i_cmd.solo_set && !i_new_solo_sel) begin
                r_armed <= 1'b0;
            end
            if (w_rearm) begin
                r_armed <= 1'b1;
            end
            if (w_act) begin
                case (i_cmd.op)
                    OP_DISPATCH: begin
                        if (w_deliver && (r_life != '0)) begin
                            r_armed <= 1'b1;
                        end
                    end
                    OP_TICK: begin
                        if (w_expire) begin
                            r_armed <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_new) begin
            r_value <= i_cmd.sig;
            r_mask  <= i_cmd.mask;
            r_life  <= i_cmd.ttl;
            r_count <= i_cmd.ttl;
        end
        if (w_rearm) begin
            r_count <= r_life;
        end
        if (w_act) begin
            case (i_cmd.op)
                OP_DISPATCH: begin
                    if (w_deliver && (r_life != '0)) begin
                        r_count <= r_life;
                    end
                end
                OP_TICK: begin
                    if (r_armed) begin
                        r_count <= w_expire ? '0 : r_count - TTL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/ssm_checker.sv
// port-level checks for signal_subscription_matcher_top, bound to the top level
// depends on ssm_pkg
module ssm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import ssm_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // only one item in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // kinds that are the sole result of their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_NONE || m_axis_tuser == KIND_SUBSCRIBED
            || m_axis_tuser == KIND_FULL) |-> m_axis_tlast)
        else $error("single result without tlast");

    // only deliveries carry a signal
    a_sig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_DELIVERED |-> m_axis_tdata[35:4] == 32'd0)
        else $error("signal on a non-delivery result");

    // nothing-to-report and table-full name no slot
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_NONE || m_axis_tuser == KIND_FULL)
            |-> m_axis_tdata[3:0] == 4'd0)
        else $error("slot set on a result without an entry");

endmodule

bind signal_subscription_matcher_top ssm_checker u_ssm_checker (.*);
